[hw/rtl/frame_luma_quality_score_unit_macros.svh]
// assertion macros used by the luma quality score back end
`ifndef FRAME_LUMA_QUALITY_SCORE_UNIT_MACROS_SVH
`define FRAME_LUMA_QUALITY_SCORE_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define FLQS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define FLQS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/flqs_pkg.sv]
// shared constants and types of the luma quality score unit
package flqs_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int COL_DIV = 64;
    localparam int ROW_DIV = 36;

    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam int RST_FRAME_WIDTH  = 640;
    localparam int RST_FRAME_HEIGHT = 360;

    localparam int PIX_W   = 8;
    localparam int LUMA_W  = 8;
    localparam int SUM_W   = 22;
    localparam int CNT_W   = 14;
    localparam int SCORE_W = 13;

    localparam int COEF_R     = 54;
    localparam int COEF_G     = 183;
    localparam int COEF_B     = 19;
    localparam int LUMA_SHIFT = 8;

    localparam int SCORE_MUL = 20;
    localparam int RANGE_MUL = 7;

    // quotient bits of floor(20*rem/count), which stays below 20
    localparam int FRAC_W = 5;
    localparam int FDVD_W = CNT_W + FRAC_W;
    localparam int STEP_W = 3;

    localparam int Q_DEPTH = 2;

    typedef struct packed {
        logic [SUM_W-1:0]  luma_sum;
        logic [LUMA_W-1:0] luma_min;
        logic [LUMA_W-1:0] luma_max;
        logic [CNT_W-1:0]  kept_count;
    } t_frame_sum;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV_MEAN,
        BK_FRAC_LOAD,
        BK_DIV_FRAC,
        BK_DONE
    } t_bk_state;

endpackage

[hw/rtl/flqs_ifs.sv]
// pixel and result channel interfaces
interface flqs_pix_if;
    import flqs_pkg::*;

    logic              valid;
    logic              ready;
    logic [PIX_W-1:0]  red;
    logic [PIX_W-1:0]  green;
    logic [PIX_W-1:0]  blue;

    modport source(output valid, red, green, blue, input ready);
    modport sink(input valid, red, green, blue, output ready);
endinterface

interface flqs_res_if;
    import flqs_pkg::*;

    logic               valid;
    logic               ready;
    logic [SCORE_W-1:0] quality_x20;
    logic [LUMA_W-1:0]  mean_luma;
    logic [LUMA_W-1:0]  min_luma;
    logic [LUMA_W-1:0]  max_luma;
    logic [CNT_W-1:0]   sample_count;

    modport source(output valid, quality_x20, mean_luma, min_luma, max_luma, sample_count,
                   input ready);
    modport sink(input valid, quality_x20, mean_luma, min_luma, max_luma, sample_count,
                 output ready);
endinterface

[hw/rtl/frame_luma_quality_score_unit.sv]
// top level of the frame luma quality score unit
//
// usage:
//   i_pix takes rgb pixels of a frame in raster order on a valid/ready
//   handshake, one item per cycle when nothing downstream is full.
//   o_res gives one item per frame after its last pixel: the score
//   (20*mean + 7*range), mean, min, max and count of the subsampled luma.
//   i_cfg_we/i_cfg_idx/i_cfg_data write frame_width (0) and frame_height (1);
//   a write restarts the frame, zero reads as 1 and large values clamp.
// division:
//   the back end divides serially, one frame summary at a time (a pop, 8
//   mean quotient bits, a load, 5 fraction bits and a finish), so frames
//   shorter than a division fill the two-entry summary queue and the
//   input then stalls until the divider frees a slot.
// reset:
//   synchronous, active low: frame size 640 x 360, empty frame, no result.
// stall:
//   a held result keeps its register and the divider waits on it; the front
//   keeps going until a frame's last pixel meets a full queue, then i_pix.ready drops.
module frame_luma_quality_score_unit #(
    parameter int MAX_WIDTH  = flqs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = flqs_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    flqs_pix_if.sink                       i_pix,
    flqs_res_if.source                     o_res,
    input  logic                           i_cfg_we,
    input  logic [flqs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [flqs_pkg::CFG_W-1:0]     i_cfg_data
);
    import flqs_pkg::*;

    logic       push;
    logic       q_full;
    logic       pop;
    logic       q_empty;
    t_frame_sum push_data;
    t_frame_sum pop_data;

    flqs_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (i_pix),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_push_data(push_data)
    );

    flqs_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_data(push_data),
        .o_full     (q_full),
        .i_pop      (pop),
        .o_pop_data (pop_data),
        .o_empty    (q_empty)
    );

    flqs_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_empty(q_empty),
        .i_data (pop_data),
        .o_pop  (pop),
        .o_res  (o_res)
    );

endmodule

[hw/rtl/flqs_front.sv]
// front end: frame position, subsampling, luma and per-frame accumulation
module flqs_front #(
    parameter int MAX_WIDTH  = flqs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = flqs_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    flqs_pix_if.sink                       i_pix,
    input  logic                           i_cfg_we,
    input  logic [flqs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [flqs_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_q_full,
    output logic                           o_push,
    output flqs_pkg::t_frame_sum           o_push_data
);
    import flqs_pkg::*;

    localparam int XW        = $clog2(MAX_WIDTH + 1);
    localparam int YW        = $clog2(MAX_HEIGHT + 1);
    localparam int CPW       = $clog2(MAX_WIDTH / COL_DIV + 1);
    localparam int RPW       = $clog2(MAX_HEIGHT / ROW_DIV + 1);
    localparam int COL_SHIFT = $clog2(COL_DIV);
    localparam int RST_W     = (RST_FRAME_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_FRAME_WIDTH;
    localparam int RST_H     = (RST_FRAME_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_FRAME_HEIGHT;
    localparam int LW        = 2 * PIX_W;

    logic [XW-1:0]     r_w, n_w;
    logic [YW-1:0]     r_h, n_h;
    logic [XW-1:0]     r_col, n_col;
    logic [YW-1:0]     r_row, n_row;
    logic [CPW-1:0]    r_cph, n_cph;
    logic [RPW-1:0]    r_rph, n_rph;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [LUMA_W-1:0] r_min, n_min;
    logic [LUMA_W-1:0] r_max, n_max;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    logic              r_p_valid, n_p_valid;
    logic              r_p_keep;
    logic              r_p_last;
    logic [LUMA_W-1:0] r_p_luma;

    logic              accept;
    logic              b_go;
    logic              keep;
    logic              col_end;
    logic              row_end;
    logic              col_wrap;
    logic              row_wrap;
    logic [LW-1:0]     luma_acc;
    logic [LUMA_W-1:0] luma;
    logic [XW-1:0]     sx_raw;
    logic [XW-1:0]     sx;
    logic [XW-1:0]     cph_inc;
    logic [YW:0]       rph_two;
    logic [YW:0]       row_thr;
    logic [CFG_W:0]    cfg_ext;
    logic [XW-1:0]     cfg_w;
    logic [YW-1:0]     cfg_h;
    logic [SUM_W-1:0]  acc_sum;
    logic [LUMA_W-1:0] acc_min;
    logic [LUMA_W-1:0] acc_max;
    logic [CNT_W-1:0]  acc_cnt;

    assign b_go        = r_p_valid && !(r_p_last && i_q_full);
    assign i_pix.ready = !r_p_valid || b_go;
    assign accept      = i_pix.valid && i_pix.ready;

    always_comb begin
        luma_acc = LW'(COEF_R) * LW'(i_pix.red) + LW'(COEF_G) * LW'(i_pix.green)
                 + LW'(COEF_B) * LW'(i_pix.blue);
        luma     = luma_acc[LW-1:LUMA_SHIFT];
    end

    // sampling grid: step_x = max(1, w/64), step_y = max(1, h/36)
    always_comb begin
        keep     = (r_cph == '0) && (r_rph == '0);
        col_end  = (r_col + XW'(1)) >= r_w;
        row_end  = (r_row + YW'(1)) >= r_h;
        sx_raw   = r_w >> COL_SHIFT;
        sx       = (sx_raw == '0) ? XW'(1) : sx_raw;
        cph_inc  = XW'(r_cph) + XW'(1);
        col_wrap = cph_inc >= sx;
        // phase+1 reaches floor(h/36) exactly when h < 36*(phase+2)
        rph_two  = (YW+1)'(r_rph) + (YW+1)'(2);
        row_thr  = rph_two * (YW+1)'(ROW_DIV);
        row_wrap = {1'b0, r_h} < row_thr;
    end

    always_comb begin
        cfg_ext = {1'b0, i_cfg_data};
        if (cfg_ext == '0) begin
            cfg_w = XW'(1);
        end else if (cfg_ext > (CFG_W+1)'(MAX_WIDTH)) begin
            cfg_w = XW'(MAX_WIDTH);
        end else begin
            cfg_w = XW'(cfg_ext);
        end
        if (cfg_ext == '0) begin
            cfg_h = YW'(1);
        end else if (cfg_ext > (CFG_W+1)'(MAX_HEIGHT)) begin
            cfg_h = YW'(MAX_HEIGHT);
        end else begin
            cfg_h = YW'(cfg_ext);
        end
    end

    always_comb begin
        acc_sum = r_p_keep ? r_sum + SUM_W'(r_p_luma) : r_sum;
        acc_min = (r_p_keep && (r_p_luma < r_min)) ? r_p_luma : r_min;
        acc_max = (r_p_keep && (r_p_luma > r_max)) ? r_p_luma : r_max;
        acc_cnt = r_p_keep ? r_cnt + CNT_W'(1) : r_cnt;
    end

    assign o_push                 = b_go && r_p_last;
    assign o_push_data.luma_sum   = acc_sum;
    assign o_push_data.luma_min   = acc_min;
    assign o_push_data.luma_max   = acc_max;
    assign o_push_data.kept_count = acc_cnt;

    always_comb begin
        n_w       = r_w;
        n_h       = r_h;
        n_col     = r_col;
        n_row     = r_row;
        n_cph     = r_cph;
        n_rph     = r_rph;
        n_sum     = r_sum;
        n_min     = r_min;
        n_max     = r_max;
        n_cnt     = r_cnt;
        n_p_valid = r_p_valid && !b_go;

        if (b_go) begin
            if (r_p_last) begin
                n_sum = '0;
                n_min = '1;
                n_max = '0;
                n_cnt = '0;
            end else begin
                n_sum = acc_sum;
                n_min = acc_min;
                n_max = acc_max;
                n_cnt = acc_cnt;
            end
        end

        if (accept) begin
            n_p_valid = 1'b1;
            if (!col_end) begin
                n_col = r_col + XW'(1);
                n_cph = col_wrap ? '0 : CPW'(cph_inc);
            end else begin
                n_col = '0;
                n_cph = '0;
                if (!row_end) begin
                    n_row = r_row + YW'(1);
                    n_rph = row_wrap ? '0 : r_rph + RPW'(1);
                end else begin
                    n_row = '0;
                    n_rph = '0;
                end
            end
        end

        // a register write restarts the frame
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRAME_WIDTH:  n_w = cfg_w;
                CFG_FRAME_HEIGHT: n_h = cfg_h;
                default: ;
            endcase
            n_col     = '0;
            n_row     = '0;
            n_cph     = '0;
            n_rph     = '0;
            n_sum     = '0;
            n_min     = '1;
            n_max     = '0;
            n_cnt     = '0;
            n_p_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w       <= XW'(RST_W);
            r_h       <= YW'(RST_H);
            r_col     <= '0;
            r_row     <= '0;
            r_cph     <= '0;
            r_rph     <= '0;
            r_sum     <= '0;
            r_min     <= '1;
            r_max     <= '0;
            r_cnt     <= '0;
            r_p_valid <= 1'b0;
        end else begin
            r_w       <= n_w;
            r_h       <= n_h;
            r_col     <= n_col;
            r_row     <= n_row;
            r_cph     <= n_cph;
            r_rph     <= n_rph;
            r_sum     <= n_sum;
            r_min     <= n_min;
            r_max     <= n_max;
            r_cnt     <= n_cnt;
            r_p_valid <= n_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p_keep <= keep;
            r_p_last <= col_end && row_end;
            r_p_luma <= luma;
        end
    end

endmodule

[hw/rtl/flqs_queue.sv]
// short queue of finished frame summaries between front and back
module flqs_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  flqs_pkg::t_frame_sum i_push_data,
    output logic                 o_full,
    input  logic                 i_pop,
    output flqs_pkg::t_frame_sum o_pop_data,
    output logic                 o_empty
);
    import flqs_pkg::*;

    localparam int PTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int FILL_W = $clog2(Q_DEPTH + 1);

    t_frame_sum        r_mem [Q_DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr;
    logic [PTR_W-1:0]  r_rd, n_rd;
    logic [FILL_W-1:0] r_fill, n_fill;

    assign o_full     = r_fill == FILL_W'(Q_DEPTH);
    assign o_empty    = r_fill == '0;
    assign o_pop_data = r_mem[r_rd];

    always_comb begin
        n_wr   = r_wr;
        n_rd   = r_rd;
        n_fill = r_fill;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_fill = r_fill + FILL_W'(1);
        end else if (i_pop && !i_push) begin
            n_fill = r_fill - FILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            r_wr   <= n_wr;
            r_rd   <= n_rd;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

[hw/rtl/flqs_back.sv]
// back end: serial mean division, score and output register
`include "frame_luma_quality_score_unit_macros.svh"

module flqs_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  flqs_pkg::t_frame_sum i_data,
    output logic                 o_pop,
    flqs_res_if.source           o_res
);
    import flqs_pkg::*;

    t_bk_state          r_state, n_state;
    t_frame_sum         r_job, n_job;
    logic [CNT_W-1:0]   r_rem, n_rem;
    logic [STEP_W-1:0]  r_step, n_step;
    logic [LUMA_W-1:0]  r_quo_m, n_quo_m;
    logic [FRAC_W-1:0]  r_quo_f, n_quo_f;
    logic [FDVD_W-1:0]  r_fdvd, n_fdvd;

    logic               r_o_valid, n_o_valid;
    logic [SCORE_W-1:0] r_o_score, n_o_score;
    logic [LUMA_W-1:0]  r_o_mean, n_o_mean;
    logic [LUMA_W-1:0]  r_o_min, n_o_min;
    logic [LUMA_W-1:0]  r_o_max, n_o_max;
    logic [CNT_W-1:0]   r_o_cnt, n_o_cnt;

    logic [LUMA_W-1:0]  mean_src;
    logic [FRAC_W-1:0]  frac_src;
    logic               div_bit;
    logic [CNT_W:0]     trial;
    logic [CNT_W:0]     diff;
    logic               ge;
    logic [CNT_W-1:0]   rem_next;
    logic [FDVD_W-1:0]  fdvd_full;
    logic [LUMA_W-1:0]  range;
    logic [SCORE_W-1:0] score;
    logic               out_free;

    assign o_res.valid        = r_o_valid;
    assign o_res.quality_x20  = r_o_score;
    assign o_res.mean_luma    = r_o_mean;
    assign o_res.min_luma     = r_o_min;
    assign o_res.max_luma     = r_o_max;
    assign o_res.sample_count = r_o_cnt;

    // one restoring step: mean quotient first, then floor(20*rem/count)
    always_comb begin
        mean_src  = r_job.luma_sum[LUMA_W-1:0];
        frac_src  = r_fdvd[FRAC_W-1:0];
        div_bit   = (r_state == BK_DIV_MEAN) ? mean_src[r_step] : frac_src[r_step];
        trial     = {r_rem, div_bit};
        diff      = trial - {1'b0, r_job.kept_count};
        ge        = trial >= {1'b0, r_job.kept_count};
        rem_next  = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        fdvd_full = FDVD_W'(r_rem) * FDVD_W'(SCORE_MUL);
        range     = r_job.luma_max - r_job.luma_min;
        score     = SCORE_W'(r_quo_m) * SCORE_W'(SCORE_MUL) + SCORE_W'(r_quo_f)
                  + SCORE_W'(range) * SCORE_W'(RANGE_MUL);
        out_free  = !r_o_valid || o_res.ready;
    end

    always_comb begin
        n_state   = r_state;
        n_job     = r_job;
        n_rem     = r_rem;
        n_step    = r_step;
        n_quo_m   = r_quo_m;
        n_quo_f   = r_quo_f;
        n_fdvd    = r_fdvd;
        n_o_valid = r_o_valid && !o_res.ready;
        n_o_score = r_o_score;
        n_o_mean  = r_o_mean;
        n_o_min   = r_o_min;
        n_o_max   = r_o_max;
        n_o_cnt   = r_o_cnt;
        o_pop     = 1'b0;

        case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_job   = i_data;
                    // sum < 256*count, so the high bits are already below count
                    n_rem   = i_data.luma_sum[SUM_W-1:LUMA_W];
                    n_step  = STEP_W'(LUMA_W - 1);
                    n_state = BK_DIV_MEAN;
                end
            end
            BK_DIV_MEAN: begin
                n_rem   = rem_next;
                n_quo_m = {r_quo_m[LUMA_W-2:0], ge};
                if (r_step == '0) begin
                    n_state = BK_FRAC_LOAD;
                end else begin
                    n_step = r_step - STEP_W'(1);
                end
            end
            BK_FRAC_LOAD: begin
                n_fdvd  = fdvd_full;
                n_rem   = fdvd_full[FDVD_W-1:FRAC_W];
                n_step  = STEP_W'(FRAC_W - 1);
                n_state = BK_DIV_FRAC;
            end
            BK_DIV_FRAC: begin
                n_rem   = rem_next;
                n_quo_f = {r_quo_f[FRAC_W-2:0], ge};
                if (r_step == '0) begin
                    n_state = BK_DONE;
                end else begin
                    n_step = r_step - STEP_W'(1);
                end
            end
            BK_DONE: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_score = score;
                    n_o_mean  = r_quo_m;
                    n_o_min   = r_job.luma_min;
                    n_o_max   = r_job.luma_max;
                    n_o_cnt   = r_job.kept_count;
                    n_state   = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job     <= n_job;
        r_rem     <= n_rem;
        r_step    <= n_step;
        r_quo_m   <= n_quo_m;
        r_quo_f   <= n_quo_f;
        r_fdvd    <= n_fdvd;
        r_o_score <= n_o_score;
        r_o_mean  <= n_o_mean;
        r_o_min   <= n_o_min;
        r_o_max   <= n_o_max;
        r_o_cnt   <= n_o_cnt;
    end

    `FLQS_ASSERT_IMPL(a_job_count_nonzero, i_clk, i_rst_n, (r_state != BK_IDLE),
        (r_job.kept_count != '0), "frame summary with zero kept pixels")
    `FLQS_ASSERT_IMPL(a_rem_below_divisor, i_clk, i_rst_n,
        (r_state == BK_DIV_MEAN || r_state == BK_DIV_FRAC),
        (r_rem < r_job.kept_count), "divider remainder not below divisor")
    `FLQS_ASSERT_NEXT(a_pop_starts_div, i_clk, i_rst_n, o_pop,
        (r_state == BK_DIV_MEAN), "pop did not start a division")
    `FLQS_ASSERT_IMPL(a_out_min_le_max, i_clk, i_rst_n, r_o_valid,
        (r_o_min <= r_o_max), "result minimum above maximum")

endmodule
